@@ design/bstk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bstk_pkg
// Shared types and constants for the bounded stack with search.
// ----------------------------------------------------------------------------
package bstk_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 6;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0]  data;
    logic                      found;
    logic        [STATUS_W-1:0] status;
    logic        [COUNT_W-1:0]  count;
    logic                      is_empty;
    logic                      is_full;
  } result_t;

endpackage
`default_nettype wire

@@ design/bounded_stack_with_search_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_stack_with_search_top
// Bounded LIFO stack of 32-bit words with push, pop, peek, clear and search.
// ----------------------------------------------------------------------------
// The words live in one memory with a single write port and a single
// registered read port; the fill count is a register. Push, clear, unused
// codes and underflowing pop or peek finish in the cycle the item is accepted.
// Pop and peek pass through S_READ for the memory read. A search reads one
// entry per cycle from the bottom of the stack up and stops at the first
// match or after the top entry; a search of an empty stack ends on accept.
// One item is worked on at a time; a finished result sits in an output
// register, and the next item is accepted while it waits to be taken.
// No clearing pass runs after reset: entries above the fill count are never
// read.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_top #(
  parameter int DEPTH = bstk_pkg::DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic        [bstk_pkg::KIND_W-1:0]    kind,
  input  wire logic signed [bstk_pkg::DATA_W-1:0]    value,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed      [bstk_pkg::DATA_W-1:0]    data,
  output logic                                       found,
  output logic             [bstk_pkg::STATUS_W-1:0]  status,
  output logic             [bstk_pkg::COUNT_W-1:0]   count,
  output logic                                       is_empty,
  output logic                                       is_full
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SRCH,
    S_DONE
  } state_t;

  state_t                          state, state_next;
  logic [CW-1:0]                   fill, fill_next;
  logic [CW-1:0]                   idx, idx_next;
  logic [CW-1:0]                   fill_dec;
  logic [bstk_pkg::DATA_W-1:0]     key;
  bstk_pkg::result_t               pend;
  bstk_pkg::result_t               res;
  logic                            fin;
  logic                            accept;
  logic                            out_free;
  logic                            hit;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [AW-1:0]                   ram_raddr;
  logic [bstk_pkg::DATA_W-1:0]     ram_rdata;

  bstk_ram #(
    .WIDTH(bstk_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign fill_dec = fill - CW'(1);
  assign hit      = (ram_rdata == key);

  always_comb begin
    state_next = state;
    fill_next  = fill;
    idx_next   = idx;
    fin        = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = fill[AW-1:0];
    ram_raddr  = idx[AW-1:0];
    res.data   = '0;
    res.found  = 1'b0;
    res.status = bstk_pkg::ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (kind)
            bstk_pkg::KIND_PUSH: begin
              fin = 1'b1;
              if (fill == CW'(DEPTH)) begin
                res.status = bstk_pkg::ST_OVERFLOW;
              end else begin
                ram_we    = 1'b1;
                fill_next = fill + CW'(1);
              end
            end
            bstk_pkg::KIND_POP, bstk_pkg::KIND_PEEK: begin
              if (fill == '0) begin
                fin        = 1'b1;
                res.status = bstk_pkg::ST_UNDERFLOW;
              end else begin
                ram_raddr  = fill_dec[AW-1:0];
                state_next = S_READ;
                if (kind == bstk_pkg::KIND_POP) begin
                  fill_next = fill_dec;
                end
              end
            end
            bstk_pkg::KIND_CLEAR: begin
              fin       = 1'b1;
              fill_next = '0;
            end
            bstk_pkg::KIND_SEARCH: begin
              if (fill == '0) begin
                fin = 1'b1;
              end else begin
                ram_raddr  = '0;
                idx_next   = CW'(1);
                state_next = S_SRCH;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        fin      = 1'b1;
        res.data = ram_rdata;
      end
      S_SRCH: begin
        // Read data belongs to entry idx-1; stop on a match or after the top.
        if (hit || idx == fill) begin
          fin       = 1'b1;
          res.found = hit;
        end else begin
          ram_raddr = idx[AW-1:0];
          idx_next  = idx + CW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
    endcase
    res.count    = bstk_pkg::COUNT_W'(fill_next);
    res.is_empty = (fill_next == '0);
    res.is_full  = (fill_next == CW'(DEPTH));
    if (fin) begin
      state_next = out_free ? S_IDLE : S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      idx   <= idx_next;
      if (accept) begin
        key <= value;
      end
      if (fin) begin
        if (out_free) begin
          out_valid <= 1'b1;
          data      <= res.data;
          found     <= res.found;
          status    <= res.status;
          count     <= res.count;
          is_empty  <= res.is_empty;
          is_full   <= res.is_full;
        end else begin
          pend <= res;
        end
      end else if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
        data      <= pend.data;
        found     <= pend.found;
        status    <= pend.status;
        count     <= pend.count;
        is_empty  <= pend.is_empty;
        is_full   <= pend.is_full;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/bstk_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bstk_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module bstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded stack with search. A queue-fed driver
// offers push, pop, peek, clear, search and spare-code items; a monitor keeps
// its own copy of the stack, predicts every result and compares it field by
// field. Both sides stall at random, with one long receiver hold-off and
// pauses that let the block drain.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH          = bstk_pkg::DEPTH_DEF;
  localparam int N_ITEMS        = 700;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 80;
  localparam int HOLD_AFTER     = 250;
  localparam int CALM_TAIL      = 100;
  localparam int TAIL_CYCLES    = 40;
  localparam int POOL_SIZE      = 40;

  // Codes the block treats as no-ops.
  localparam logic [bstk_pkg::KIND_W-1:0] KIND_SPARE5 = 3'd5;
  localparam logic [bstk_pkg::KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [bstk_pkg::KIND_W-1:0] KIND_SPARE7 = 3'd7;

  typedef struct {
    bit                                 drain;
    logic [bstk_pkg::KIND_W-1:0]        kind;
    logic signed [bstk_pkg::DATA_W-1:0] value;
  } stack_op_t;

  logic                                 clk       = 1'b0;
  logic                                 rst       = 1'b1;
  logic                                 in_valid  = 1'b0;
  logic                                 in_ready;
  logic [bstk_pkg::KIND_W-1:0]          kind      = bstk_pkg::KIND_PUSH;
  logic signed [bstk_pkg::DATA_W-1:0]   value     = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [bstk_pkg::DATA_W-1:0]   data;
  logic                                 found;
  logic [bstk_pkg::STATUS_W-1:0]        status;
  logic [bstk_pkg::COUNT_W-1:0]         count;
  logic                                 is_empty;
  logic                                 is_full;

  stack_op_t                   pending_ops [$];
  logic [bstk_pkg::DATA_W-1:0] recent_words [$];
  int                          n_planned = 0;

  // Stack model and the results it predicts.
  logic [bstk_pkg::DATA_W-1:0] model_words [DEPTH];
  int unsigned                 model_fill = 0;
  bstk_pkg::result_t           expected_results [$];

  int n_errors    = 0;
  int n_sent      = 0;
  int n_in        = 0;
  int n_done      = 0;
  int n_push      = 0;
  int n_read      = 0;
  int n_search    = 0;
  int n_found     = 0;
  int n_overflow  = 0;
  int n_underflow = 0;

  int send_gap   = 0;
  bit send_quiet = 1'b0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;
  int recv_stall = 0;
  bit recv_quiet = 1'b0;

  bounded_stack_with_search_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .data     (data),
    .found    (found),
    .status   (status),
    .count    (count),
    .is_empty (is_empty),
    .is_full  (is_full)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bstk_pkg::result_t stack_predict(logic [bstk_pkg::KIND_W-1:0] op,
                                                      logic [bstk_pkg::DATA_W-1:0] word);
    bstk_pkg::result_t r;
    r = '0;
    r.status = bstk_pkg::ST_OK;
    case (op)
      bstk_pkg::KIND_PUSH: begin
        n_push++;
        if (model_fill >= DEPTH) begin
          r.status = bstk_pkg::ST_OVERFLOW;
          n_overflow++;
        end else begin
          model_words[model_fill] = word;
          model_fill++;
        end
      end
      bstk_pkg::KIND_POP, bstk_pkg::KIND_PEEK: begin
        n_read++;
        if (model_fill == 0) begin
          r.status = bstk_pkg::ST_UNDERFLOW;
          n_underflow++;
        end else begin
          r.data = model_words[model_fill - 1];
          if (op == bstk_pkg::KIND_POP) model_fill--;
        end
      end
      bstk_pkg::KIND_CLEAR: begin
        model_fill = 0;
      end
      bstk_pkg::KIND_SEARCH: begin
        n_search++;
        for (int i = 0; i < model_fill; i++) begin
          if (model_words[i] == word) r.found = 1'b1;
        end
        if (r.found) n_found++;
      end
      default: ;
    endcase
    r.count    = model_fill[bstk_pkg::COUNT_W-1:0];
    r.is_empty = (model_fill == 0);
    r.is_full  = (model_fill == DEPTH);
    return r;
  endfunction

  task automatic check_field(string name, logic [bstk_pkg::DATA_W-1:0] want,
                             logic [bstk_pkg::DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  task automatic add_op(logic [bstk_pkg::KIND_W-1:0] op, logic [bstk_pkg::DATA_W-1:0] word);
    stack_op_t item;
    item.drain = 1'b0;
    item.kind  = op;
    item.value = word;
    pending_ops.push_back(item);
    n_planned++;
    if (op == bstk_pkg::KIND_PUSH) begin
      recent_words.push_back(word);
      if (recent_words.size() > POOL_SIZE) void'(recent_words.pop_front());
    end
  endtask

  task automatic add_drain();
    stack_op_t item;
    item.drain = 1'b1;
    item.kind  = bstk_pkg::KIND_PUSH;
    item.value = '0;
    pending_ops.push_back(item);
  endtask

  // Mostly words that were pushed recently, so that searches hit.
  function automatic logic [bstk_pkg::DATA_W-1:0] search_word();
    if (recent_words.size() != 0 && $urandom_range(0, 9) < 6)
      return recent_words[$urandom_range(0, recent_words.size() - 1)];
    return $urandom();
  endfunction

  // Driver: offers the pending items in order, with random gaps.
  always @(posedge clk) begin
    stack_op_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) n_sent++;
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() != 0 && pending_ops[0].drain) begin
          // Hold back until every accepted item has produced its result.
          in_valid <= 1'b0;
          if (n_done == n_sent) void'(pending_ops.pop_front());
        end else if (pending_ops.size() != 0) begin
          nxt = pending_ops.pop_front();
          in_valid <= 1'b1;
          kind     <= nxt.kind;
          value    <= nxt.value;
          if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
          if (!send_quiet && n_sent + CALM_TAIL < n_planned && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on every accepted item, checks every accepted result,
  // and drives the receiver's ready.
  always @(posedge clk) begin
    bstk_pkg::result_t want;
    bit                rdy;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(stack_predict(kind, value));
        n_in++;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no item pending: data %0h status %0h count %0d",
                   $time, data, status, count);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("data", want.data, data);
          check_field("found", want.found, found);
          check_field("status", want.status, status);
          check_field("count", want.count, count);
          check_field("is_empty", want.is_empty, is_empty);
          check_field("is_full", want.is_full, is_full);
        end
        n_done <= n_done + 1;
      end

      rdy = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && n_in >= HOLD_AFTER) begin
        // One long hold-off so that the block backs up and stalls its input.
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rdy = 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        rdy = 1'b0;
      end else if (!recv_quiet && n_in + CALM_TAIL < n_planned && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(0, 7);
        rdy = 1'b0;
      end
      if ($urandom_range(0, 40) == 0) recv_quiet = !recv_quiet;
      out_ready <= rdy;
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    int len;

    // Underflow, empty search and spare codes on an empty stack.
    add_op(bstk_pkg::KIND_POP, 32'h0);
    add_op(bstk_pkg::KIND_PEEK, 32'h0);
    add_op(bstk_pkg::KIND_SEARCH, 32'h0);
    add_op(KIND_SPARE5, 32'hFFFF_FFFF);
    add_op(KIND_SPARE6, 32'h0);
    add_op(KIND_SPARE7, 32'h0);
    // Extreme words, then searches at the bottom, the middle and a miss.
    add_op(bstk_pkg::KIND_PUSH, 32'h7FFF_FFFF);
    add_op(bstk_pkg::KIND_PUSH, 32'h8000_0000);
    add_op(bstk_pkg::KIND_PUSH, 32'h0000_0000);
    add_op(bstk_pkg::KIND_PUSH, 32'hFFFF_FFFF);
    add_op(bstk_pkg::KIND_SEARCH, 32'h8000_0000);
    add_op(bstk_pkg::KIND_SEARCH, 32'h7FFF_FFFF);
    add_op(bstk_pkg::KIND_SEARCH, 32'h1234_5678);
    add_op(bstk_pkg::KIND_PEEK, 32'h0);
    add_op(bstk_pkg::KIND_POP, 32'h0);
    // A popped word is still in memory but must not be found.
    add_op(bstk_pkg::KIND_SEARCH, 32'hFFFF_FFFF);
    add_op(KIND_SPARE7, 32'h5555_5555);
    add_op(bstk_pkg::KIND_CLEAR, 32'h0);
    add_op(bstk_pkg::KIND_SEARCH, 32'h0);
    add_op(bstk_pkg::KIND_POP, 32'h0);
    add_op(bstk_pkg::KIND_PUSH, 32'h5555_5555);
    add_op(bstk_pkg::KIND_PUSH, 32'hAAAA_AAAA);
    add_op(bstk_pkg::KIND_POP, 32'h0);
    add_op(bstk_pkg::KIND_POP, 32'h0);
    add_drain();

    // Fill to the top and push past it.
    for (int i = 0; i < DEPTH + 2; i++) add_op(bstk_pkg::KIND_PUSH, $urandom());
    add_op(bstk_pkg::KIND_SEARCH, search_word());
    add_op(bstk_pkg::KIND_PEEK, 32'h0);

    while (n_planned < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        len = $urandom_range(1, 10);
        repeat (len) add_op(bstk_pkg::KIND_PUSH, $urandom());
      end else if (pick < 50) begin
        len = $urandom_range(1, 9);
        repeat (len) add_op(bstk_pkg::KIND_POP, $urandom());
      end else if (pick < 58) begin
        len = $urandom_range(1, 3);
        repeat (len) add_op(bstk_pkg::KIND_PEEK, $urandom());
      end else if (pick < 76) begin
        len = $urandom_range(1, 4);
        repeat (len) add_op(bstk_pkg::KIND_SEARCH, search_word());
      end else if (pick < 80) begin
        repeat (DEPTH + 3) add_op(bstk_pkg::KIND_PUSH, $urandom());
      end else if (pick < 85) begin
        add_op(bstk_pkg::KIND_CLEAR, $urandom());
      end else if (pick < 88) begin
        add_op(KIND_SPARE5 + 3'($urandom_range(0, 2)), $urandom());
      end else if (pick < 91) begin
        // No drain pauses in the last part of the run.
        if (n_planned + CALM_TAIL < N_ITEMS) add_drain();
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) add_op(3'($urandom_range(0, 7)), $urandom());
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || n_done != n_sent);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      n_errors += expected_results.size();
    end

    $display("Checked %0d results from %0d items: %0d pushes (%0d dropped when full),",
             n_done, n_in, n_push, n_overflow);
    $display("  %0d pops/peeks (%0d on an empty stack), %0d searches (%0d hits).",
             n_read, n_underflow, n_search, n_found);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
